// ----- rtl/grid_maze_dfs_path_marker_defines.svh -----
// assertion helpers for the maze solver
`ifndef GRID_MAZE_DFS_PATH_MARKER_DEFINES_SVH
`define GRID_MAZE_DFS_PATH_MARKER_DEFINES_SVH

// same-cycle implication
`define GMD_ASSERT_NOW(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("gmd check failed");

// next-cycle implication
`define GMD_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("gmd check failed");

`endif

// ----- rtl/gmd_pkg.sv -----
package gmd_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam logic [6:0] DIM_RESET = 7'd64;

  localparam logic [7:0] WALL_CH   = 8'h2A;
  localparam logic [7:0] START_CH  = 8'h53;
  localparam logic [7:0] FINISH_CH = 8'h46;
  localparam logic [7:0] PATH_CH   = 8'h2E;

  localparam logic [2:0] DIR_LEFT  = 3'd0;
  localparam logic [2:0] DIR_RIGHT = 3'd1;
  localparam logic [2:0] DIR_UP    = 3'd2;
  localparam logic [2:0] DIR_DOWN  = 3'd3;
  localparam logic [2:0] DIR_DONE  = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR_RST,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_START,
    ST_START_CHK,
    ST_STEP,
    ST_CHECK,
    ST_POP,
    ST_MARK,
    ST_MARK_WR
  } state_t;

endpackage

// ----- rtl/gmd_if.sv -----
interface gmd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] cell_x;
  logic [5:0] cell_y;
  logic [7:0] cell_char;
  modport source (output valid, opcode, cell_x, cell_y, cell_char, input ready);
  modport sink (input valid, opcode, cell_x, cell_y, cell_char, output ready);
endinterface

interface gmd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_out;
  logic       path_found;
  logic       out_of_range;
  modport source (output valid, cell_out, path_found, out_of_range, input ready);
  modport sink (input valid, cell_out, path_found, out_of_range, output ready);
endinterface

// ----- rtl/gmd_ram.sv -----
module gmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/grid_maze_dfs_path_marker.sv -----
// Depth-first grid maze solver. A cell write or an unused opcode is answered
// from idle, a cell read via a read state. A solve first sweeps the visited
// and path mark memories, one cell a cycle over all 2^(2*clog2(MAX_SIDE))
// cells (4096 at the default), then walks the search: a probe passes a step
// and a check state, a backtrack a step and a pop state, and a found path is
// marked cell by cell. After reset the same sweep runs once before the first
// word is taken. A word is taken only into an empty result register: one in flight.
module grid_maze_dfs_path_marker #(
  parameter int MAX_SIDE = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  gmd_in_if.sink     in_ch,
  gmd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data
);

  import gmd_pkg::*;

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int AW    = 2 * CW;
  localparam int CELLS = 1 << AW;
  localparam int SW    = AW + 3;

  state_t state_r, state_nxt;

  logic [6:0]    width_r, height_r;
  logic [5:0]    start_x_r, start_y_r, fin_x_r, fin_y_r;
  logic [5:0]    start_x_nxt, start_y_nxt, fin_x_nxt, fin_y_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW:0]   sp_r, sp_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] top_cell_r, top_cell_nxt;
  logic [2:0]    top_dir_r, top_dir_nxt;
  logic [AW-1:0] nb_r, nb_nxt;
  logic          rd_oor_r, rd_oor_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    cell_out_r, cell_out_nxt;
  logic          found_r, found_nxt;
  logic          oor_r, oor_nxt;

  logic          cell_we;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [7:0]    cell_rdata;
  logic          visit_we, visit_wdata, visit_rdata;
  logic [AW-1:0] visit_waddr;
  logic          path_we, path_wdata, path_rdata;
  logic [AW-1:0] path_waddr;
  logic          stack_we;
  logic [AW-1:0] stack_waddr, stack_raddr;
  logic [SW-1:0] stack_rdata;

  logic [7:0]    w_eff, h_eff;
  logic [6:0]    in_x7, in_y7, sx7, sy7;
  logic [AW-1:0] in_idx, start_idx;
  logic          in_oor, sf_oor;
  logic          in_acc;
  logic [CW-1:0] tx, ty, nx, ny;
  logic          nb_ok, nb_fin;

  function automatic logic [7:0] eff_dim(input logic [6:0] v);
    logic [7:0] r;
    r = {1'b0, v};
    if (v == '0) begin
      r = 8'd1;
    end else if (r > 8'(MAX_SIDE)) begin
      r = 8'(MAX_SIDE);
    end
    return r;
  endfunction

  assign w_eff     = eff_dim(width_r);
  assign h_eff     = eff_dim(height_r);
  assign in_x7     = {1'b0, in_ch.cell_x};
  assign in_y7     = {1'b0, in_ch.cell_y};
  assign sx7       = {1'b0, start_x_r};
  assign sy7       = {1'b0, start_y_r};
  assign in_idx    = {in_y7[CW-1:0], in_x7[CW-1:0]};
  assign start_idx = {sy7[CW-1:0], sx7[CW-1:0]};
  assign in_oor    = ({2'b0, in_ch.cell_x} >= w_eff) || ({2'b0, in_ch.cell_y} >= h_eff);
  assign sf_oor    = ({2'b0, start_x_r} >= w_eff) || ({2'b0, start_y_r} >= h_eff) ||
                     ({2'b0, fin_x_r} >= w_eff) || ({2'b0, fin_y_r} >= h_eff);

  assign in_ch.ready      = (state_r == ST_IDLE) && !out_valid_r;
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.cell_out     = cell_out_r;
  assign out_ch.path_found   = found_r;
  assign out_ch.out_of_range = oor_r;

  // neighbour of the stack top in the direction under trial
  assign tx = top_cell_r[CW-1:0];
  assign ty = top_cell_r[AW-1:CW];
  always_comb begin
    nx    = tx;
    ny    = ty;
    nb_ok = 1'b0;
    case (top_dir_r)
      DIR_LEFT: begin
        nb_ok = (tx != '0);
        nx    = tx - CW'(1);
      end
      DIR_RIGHT: begin
        nb_ok = ((8'(tx) + 8'd1) < w_eff);
        nx    = tx + CW'(1);
      end
      DIR_UP: begin
        nb_ok = (ty != '0);
        ny    = ty - CW'(1);
      end
      DIR_DOWN: begin
        nb_ok = ((8'(ty) + 8'd1) < h_eff);
        ny    = ty + CW'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end
  assign nb_fin = (8'(nx) == 8'(fin_x_r)) && (8'(ny) == 8'(fin_y_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR_RST: if (clr_r == AW'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc && in_ch.opcode == OP_READ) begin
          state_nxt = ST_READ;
        end else if (in_acc && in_ch.opcode == OP_SOLVE) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_CLEAR: if (clr_r == AW'(CELLS - 1)) state_nxt = ST_START;
      ST_START: begin
        if (sf_oor || (start_x_r == fin_x_r && start_y_r == fin_y_r)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_START_CHK;
        end
      end
      ST_START_CHK: state_nxt = (cell_rdata == WALL_CH) ? ST_IDLE : ST_STEP;
      ST_STEP: begin
        if (top_dir_r >= DIR_DONE) begin
          state_nxt = (sp_r == (AW+1)'(1)) ? ST_IDLE : ST_POP;
        end else if (nb_ok && nb_fin) begin
          state_nxt = ST_MARK;
        end else if (nb_ok) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: state_nxt = ST_STEP;
      ST_POP: state_nxt = ST_STEP;
      ST_MARK: state_nxt = (sp_r == (AW+1)'(1)) ? ST_IDLE : ST_MARK_WR;
      ST_MARK_WR: if ((AW+1)'(idx_r) + (AW+1)'(2) == sp_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_nxt       = clr_r;
    sp_nxt        = sp_r;
    idx_nxt       = idx_r;
    top_cell_nxt  = top_cell_r;
    top_dir_nxt   = top_dir_r;
    nb_nxt        = nb_r;
    rd_oor_nxt    = rd_oor_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    fin_x_nxt     = fin_x_r;
    fin_y_nxt     = fin_y_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cell_out_nxt  = cell_out_r;
    found_nxt     = found_r;
    oor_nxt       = oor_r;
    cell_we       = 1'b0;
    cell_waddr    = in_idx;
    cell_raddr    = in_idx;
    visit_we      = 1'b0;
    visit_waddr   = clr_r;
    visit_wdata   = 1'b0;
    path_we       = 1'b0;
    path_waddr    = clr_r;
    path_wdata    = 1'b0;
    stack_we      = 1'b0;
    stack_waddr   = sp_r[AW-1:0] - AW'(1);
    stack_raddr   = sp_r[AW-1:0] - AW'(2);
    case (state_r)
      ST_CLEAR_RST, ST_CLEAR: begin
        visit_we = 1'b1;
        path_we  = 1'b1;
        clr_nxt  = clr_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          rd_oor_nxt   = in_oor;
          cell_out_nxt = '0;
          found_nxt    = 1'b0;
          oor_nxt      = 1'b0;
          case (in_ch.opcode)
            OP_WRITE: begin
              out_valid_nxt = 1'b1;
              oor_nxt       = in_oor;
              if (!in_oor) begin
                cell_we = 1'b1;
                if (in_ch.cell_char == START_CH) begin
                  start_x_nxt = in_ch.cell_x;
                  start_y_nxt = in_ch.cell_y;
                end else if (in_ch.cell_char == FINISH_CH) begin
                  fin_x_nxt = in_ch.cell_x;
                  fin_y_nxt = in_ch.cell_y;
                end
              end
            end
            OP_READ, OP_SOLVE: ;
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        oor_nxt       = rd_oor_r;
        if (rd_oor_r) begin
          cell_out_nxt = '0;
        end else if (cell_rdata == START_CH || cell_rdata == FINISH_CH) begin
          cell_out_nxt = cell_rdata;
        end else if (path_rdata) begin
          cell_out_nxt = PATH_CH;
        end else begin
          cell_out_nxt = cell_rdata;
        end
      end
      ST_START: begin
        cell_raddr = start_idx;
        if (sf_oor) begin
          out_valid_nxt = 1'b1;
          oor_nxt       = 1'b1;
        end else if (start_x_r == fin_x_r && start_y_r == fin_y_r) begin
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b1;
        end
      end
      ST_START_CHK: begin
        if (cell_rdata == WALL_CH) begin
          out_valid_nxt = 1'b1;
        end else begin
          visit_we     = 1'b1;
          visit_waddr  = start_idx;
          visit_wdata  = 1'b1;
          top_cell_nxt = start_idx;
          top_dir_nxt  = DIR_LEFT;
          sp_nxt       = (AW+1)'(1);
        end
      end
      ST_STEP: begin
        cell_raddr = {ny, nx};
        if (top_dir_r >= DIR_DONE) begin
          sp_nxt = sp_r - (AW+1)'(1);
          if (sp_r == (AW+1)'(1)) begin
            out_valid_nxt = 1'b1;
          end
        end else begin
          top_dir_nxt = top_dir_r + 3'd1;
          nb_nxt      = {ny, nx};
          if (nb_ok && nb_fin) begin
            path_we    = 1'b1;
            path_waddr = top_cell_r;
            path_wdata = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (cell_rdata != WALL_CH && !visit_rdata) begin
          visit_we     = 1'b1;
          visit_waddr  = nb_r;
          visit_wdata  = 1'b1;
          stack_we     = 1'b1;
          top_cell_nxt = nb_r;
          top_dir_nxt  = DIR_LEFT;
          sp_nxt       = sp_r + (AW+1)'(1);
        end
      end
      ST_POP: begin
        top_cell_nxt = stack_rdata[SW-1:3];
        top_dir_nxt  = stack_rdata[2:0];
      end
      ST_MARK: begin
        stack_raddr = '0;
        idx_nxt     = '0;
        if (sp_r == (AW+1)'(1)) begin
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b1;
        end
      end
      ST_MARK_WR: begin
        path_we     = 1'b1;
        path_waddr  = stack_rdata[SW-1:3];
        path_wdata  = 1'b1;
        stack_raddr = idx_r + AW'(1);
        idx_nxt     = idx_r + AW'(1);
        if ((AW+1)'(idx_r) + (AW+1)'(2) == sp_r) begin
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // visited neighbour probe shares the cell read address
  logic [AW-1:0] visit_raddr;
  assign visit_raddr = cell_raddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR_RST;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      width_r     <= DIM_RESET;
      height_r    <= DIM_RESET;
      start_x_r   <= '0;
      start_y_r   <= '0;
      fin_x_r     <= '0;
      fin_y_r     <= '0;
      sp_r        <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      fin_x_r     <= fin_x_nxt;
      fin_y_r     <= fin_y_nxt;
      sp_r        <= sp_nxt;
      idx_r       <= idx_nxt;
      if (cfg_we && cfg_index == REG_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_cell_r <= top_cell_nxt;
    top_dir_r  <= top_dir_nxt;
    nb_r       <= nb_nxt;
    rd_oor_r   <= rd_oor_nxt;
    cell_out_r <= cell_out_nxt;
    found_r    <= found_nxt;
    oor_r      <= oor_nxt;
  end

  gmd_ram #(.WIDTH(8), .DEPTH(CELLS)) u_cell_ram (
    .clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(in_ch.cell_char),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );

  gmd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visit_ram (
    .clk(clk), .we(visit_we), .waddr(visit_waddr), .wdata(visit_wdata),
    .raddr(visit_raddr), .rdata(visit_rdata)
  );

  gmd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_path_ram (
    .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
    .raddr(in_idx), .rdata(path_rdata)
  );

  gmd_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack_ram (
    .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata({top_cell_r, top_dir_r}),
    .raddr(stack_raddr), .rdata(stack_rdata)
  );

endmodule

// ----- rtl/gmd_checker.sv -----
module gmd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] cell_out,
  input logic       path_found
);

  `include "grid_maze_dfs_path_marker_defines.svh"

  // a waiting result word stays offered
  `GMD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // one word in flight at a time
  `GMD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
  `GMD_ASSERT_NOW(a_no_take_while_full, clk, rst_n, out_valid, !in_ready)
  // a read result never reports a found path
  `GMD_ASSERT_NOW(a_read_no_found, clk, rst_n, out_valid && cell_out != 8'd0, !path_found)

endmodule

bind grid_maze_dfs_path_marker gmd_checker u_gmd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .cell_out(out_ch.cell_out),
  .path_found(out_ch.path_found)
);
